FILE: rtl/tpi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Turtle path interpreter package
// Item types, symbol and register codes, reset values and the fixed-point
// constants shared by the interpreter and its testbench.
// ----------------------------------------------------------------------------
package tpi_pkg;

    // Default sizes of the pose stack and the sine table.
    localparam int DEF_STACK_DEPTH  = 64;
    localparam int DEF_TRIG_ENTRIES = 1024;

    // Field widths.
    localparam int HEAD_W  = 16;
    localparam int STEP_W  = 19;
    localparam int POS_W   = 20;
    localparam int QS_W    = 15;            // unsigned Q1.14, 0 .. 16384
    localparam int TRIG_W  = 16;            // signed Q1.14
    localparam int PROD_W  = 36;
    localparam int FRAC_W  = 14;
    localparam int DELTA_W = PROD_W - FRAC_W;
    localparam int SUM_W   = DELTA_W + 1;

    localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(8192);
    localparam logic signed [POS_W-1:0]  POS_MAX    = 20'sd524287;
    localparam logic signed [POS_W-1:0]  POS_MIN    = -20'sd524288;

    // Configuration port.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 20;

    localparam logic [CFG_INDEX_W-1:0] REG_TURN_STEP     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_LENGTH   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_START_X       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_START_Y       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_START_HEADING = 3'd4;

    localparam logic [HEAD_W-1:0]       TURN_STEP_RST  = 16'd4551;
    localparam logic [STEP_W-1:0]       STEP_LEN_RST   = 19'd2560;
    localparam logic signed [POS_W-1:0] START_X_RST    = 20'sd76800;
    localparam logic signed [POS_W-1:0] START_Y_RST    = 20'sd140800;
    localparam logic [HEAD_W-1:0]       START_HEAD_RST = 16'd16384;

    // Turtle symbols.
    localparam logic [7:0] SYM_FORWARD = 8'h46;   // F
    localparam logic [7:0] SYM_LEFT    = 8'h2B;   // +
    localparam logic [7:0] SYM_RIGHT   = 8'h2D;   // -
    localparam logic [7:0] SYM_PUSH    = 8'h5B;   // [
    localparam logic [7:0] SYM_POP     = 8'h5D;   // ]

    // Taylor series for the first-quadrant sine, built at elaboration.
    localparam longint unsigned PI_Q30       = 64'd3373259426;
    localparam int              TAYLOR_TERMS = 10;
    localparam longint unsigned TAYLOR_DIV [TAYLOR_TERMS] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
          64'd156, 64'd210, 64'd272, 64'd342, 64'd420};

    typedef enum logic [1:0] {
        KIND_SEGMENT   = 2'd0,
        KIND_OVERFLOW  = 2'd1,
        KIND_UNDERFLOW = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_FWD  = 3'd1,
        OP_PUSH = 3'd2,
        OP_POP  = 3'd3,
        OP_OVF  = 3'd4,
        OP_UNF  = 3'd5
    } op_t;

    typedef struct packed {
        logic [7:0] symbol;
        logic       start_flag;
    } tpi_in_t;

    typedef struct packed {
        kind_t                    kind;
        logic signed [POS_W-1:0]  from_x;
        logic signed [POS_W-1:0]  from_y;
        logic signed [POS_W-1:0]  to_x;
        logic signed [POS_W-1:0]  to_y;
    } tpi_out_t;

    typedef struct packed {
        logic [HEAD_W-1:0]       heading;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
    } pose_t;

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
        logic signed [POS_W-1:0] r;
        if (v > SUM_W'(POS_MAX)) begin
            r = POS_MAX;
        end else if (v < SUM_W'(POS_MIN)) begin
            r = POS_MIN;
        end else begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/tpi_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module tpi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/turtle_path_interpreter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Turtle path interpreter
// Runs a stream of turtle symbols: moves, turns, pushes and pops poses on a
// stack held in RAM, and emits line segments and stack error items.
// ----------------------------------------------------------------------------
// Pipeline: an accepted item passes stage B, then stage C, which loads any result into the m_ register.
// Throughput: one item per cycle unless a result stalls on m_ready. A ']'
// waits while a '[' ahead of it is still writing its pose into the stack RAM.
// Reset (synchronous, aresetn low): control registers return to their
// defaults, the pose is the default start pose and the stack is empty.
// Stack RAM contents are not cleared; no entry is read before a push writes it.
// ----------------------------------------------------------------------------
module turtle_path_interpreter
    import tpi_pkg::*;
#(
    parameter int STACK_DEPTH  = DEF_STACK_DEPTH,
    parameter int TRIG_ENTRIES = DEF_TRIG_ENTRIES
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  tpi_in_t                s_data,

    output logic                   m_valid,
    input  logic                   m_ready,
    output tpi_out_t               m_data
);

    localparam int CW  = $clog2(STACK_DEPTH + 1);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int IW  = $clog2(TRIG_ENTRIES);
    localparam int RAW = $clog2(TRIG_ENTRIES + 1);
    localparam int PW  = $clog2(5 * TRIG_ENTRIES);
    localparam int HPW = HEAD_W + RAW;
    localparam longint unsigned QUARTER_DIV = 64'(2 * TRIG_ENTRIES);

    typedef logic [QS_W-1:0] qs_table_t [TRIG_ENTRIES + 1];

    typedef struct packed {
        logic           neg;
        logic [RAW-1:0] addr;
    } trig_sel_t;

    // First-quadrant sine table, entry u = sin((pi/2) * u / TRIG_ENTRIES).
    function automatic qs_table_t build_qs_table();
        qs_table_t       tbl;
        longint unsigned x;
        longint unsigned term;
        longint          sum;
        for (int u = 0; u <= TRIG_ENTRIES; u++) begin
            x    = (PI_Q30 * 64'(u)) / QUARTER_DIV;
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= TAYLOR_TERMS; n++) begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / TAYLOR_DIV[n-1];
                if ((n & 1) == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            tbl[u] = QS_W'((64'(sum) + 64'd32768) >> 16);
        end
        return tbl;
    endfunction

    localparam qs_table_t QS_TABLE = build_qs_table();

    // Folds a phase (one step per table entry) onto the quarter table.
    function automatic trig_sel_t phase_map(input logic [PW-1:0] ph);
        trig_sel_t      sel;
        logic [PW-1:0]  a;
        priority if (ph < PW'(TRIG_ENTRIES)) begin
            a       = ph;
            sel.neg = 1'b0;
        end else if (ph < PW'(2 * TRIG_ENTRIES)) begin
            a       = PW'(2 * TRIG_ENTRIES) - ph;
            sel.neg = 1'b0;
        end else if (ph < PW'(3 * TRIG_ENTRIES)) begin
            a       = ph - PW'(2 * TRIG_ENTRIES);
            sel.neg = 1'b1;
        end else begin
            a       = PW'(4 * TRIG_ENTRIES) - ph;
            sel.neg = 1'b1;
        end
        sel.addr = a[RAW-1:0];
        return sel;
    endfunction

    // Configuration registers.
    logic [HEAD_W-1:0]       turn_step_reg;
    logic [STEP_W-1:0]       step_len_reg;
    logic signed [POS_W-1:0] start_x_reg;
    logic signed [POS_W-1:0] start_y_reg;
    logic [HEAD_W-1:0]       start_head_reg;

    // Front-end state.
    logic [HEAD_W-1:0] heading_reg, heading_next;
    logic [CW-1:0]     count_reg, count_next;

    // Stage B.
    logic              b_valid_reg;
    op_t               b_op_reg;
    logic              b_start_reg;
    logic [HEAD_W-1:0] b_head_reg;
    logic [SAW-1:0]    b_addr_reg;
    logic              b_negc_reg;
    logic              b_negs_reg;
    logic [QS_W-1:0]   rom_cos_reg;
    logic [QS_W-1:0]   rom_sin_reg;

    // Stage C.
    logic                     c_valid_reg;
    op_t                      c_op_reg;
    logic                     c_start_reg;
    logic [HEAD_W-1:0]        c_head_reg;
    logic [SAW-1:0]           c_addr_reg;
    logic signed [PROD_W-1:0] c_prod_x_reg;
    logic signed [PROD_W-1:0] c_prod_y_reg;
    pose_t                    c_pop_reg;

    logic signed [POS_W-1:0] pos_x_reg, pos_x_next;
    logic signed [POS_W-1:0] pos_y_reg, pos_y_next;

    logic     m_valid_reg;
    tpi_out_t m_data_reg;
    tpi_out_t c_result;

    // Handshake and stage movement.
    logic out_free, c_res, c_done, en_bc, en_ab, push_busy, accept;

    // Front-end decode.
    logic [HEAD_W-1:0] heading_eff, head_cur, heading_a;
    logic [CW-1:0]     count_cur, count_a;
    op_t               op_a;
    logic [HPW-1:0]    head_prod;
    logic [PW-1:0]     ph_sin, ph_cos;
    trig_sel_t         sin_sel, cos_sel;

    // Stack RAM.
    pose_t ram_rdata, ram_wdata;
    logic  ram_we, ram_re;

    // Stage B arithmetic.
    logic signed [TRIG_W-1:0] cos_mag, sin_mag, cos_v, ysin_v;
    logic signed [PROD_W-1:0] len_ext, prod_x, prod_y;

    // Stage C arithmetic.
    logic signed [POS_W-1:0]  base_x, base_y, new_x, new_y;
    logic signed [PROD_W-1:0] rnd_x, rnd_y;
    logic signed [SUM_W-1:0]  sum_x, sum_y;

    assign out_free  = !m_valid_reg || m_ready;
    assign c_res     = (c_op_reg == OP_FWD) || (c_op_reg == OP_OVF) || (c_op_reg == OP_UNF);
    assign c_done    = c_valid_reg && (!c_res || out_free);
    assign en_bc     = !c_valid_reg || c_done;
    assign en_ab     = !b_valid_reg || en_bc;
    assign push_busy = (b_valid_reg && (b_op_reg == OP_PUSH))
                    || (c_valid_reg && (c_op_reg == OP_PUSH));
    // A pop must not read the stack before an older push has written it.
    assign s_ready   = en_ab && !((s_data.symbol == SYM_POP) && push_busy);
    assign accept    = s_valid && s_ready;

    always_comb begin
        // The heading of a pop still in stage B comes straight from the RAM.
        heading_eff = (b_valid_reg && (b_op_reg == OP_POP)) ? ram_rdata.heading : heading_reg;
        head_cur    = s_data.start_flag ? start_head_reg : heading_eff;
        count_cur   = s_data.start_flag ? '0 : count_reg;
        op_a        = OP_NONE;
        heading_a   = head_cur;
        count_a     = count_cur;
        unique case (s_data.symbol)
            SYM_FORWARD: begin
                op_a = OP_FWD;
            end
            SYM_LEFT: begin
                heading_a = head_cur + turn_step_reg;
            end
            SYM_RIGHT: begin
                heading_a = head_cur - turn_step_reg;
            end
            SYM_PUSH: begin
                if (count_cur == CW'(STACK_DEPTH)) begin
                    op_a = OP_OVF;
                end else begin
                    op_a    = OP_PUSH;
                    count_a = count_cur + 1'b1;
                end
            end
            SYM_POP: begin
                if (count_cur == '0) begin
                    op_a = OP_UNF;
                end else begin
                    op_a    = OP_POP;
                    count_a = count_cur - 1'b1;
                end
            end
            default: begin
            end
        endcase
        heading_next = accept ? heading_a : heading_eff;
        count_next   = accept ? count_a : count_reg;
    end

    always_comb begin
        head_prod = HPW'(head_cur) * HPW'(TRIG_ENTRIES);
        ph_sin    = PW'({head_prod[HEAD_W +: IW], 2'b00});
        ph_cos    = ph_sin + PW'(TRIG_ENTRIES);
        if (ph_cos >= PW'(4 * TRIG_ENTRIES)) begin
            ph_cos = ph_cos - PW'(4 * TRIG_ENTRIES);
        end
        sin_sel = phase_map(ph_sin);
        cos_sel = phase_map(ph_cos);
    end

    assign ram_re = accept && (op_a == OP_POP);

    tpi_ram #(
        .WIDTH ($bits(pose_t)),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (c_addr_reg),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (count_a[SAW-1:0]),
        .rd_data (ram_rdata)
    );

    // Stage B: sign the table values and multiply by the step length.
    always_comb begin
        cos_mag = $signed({1'b0, rom_cos_reg});
        sin_mag = $signed({1'b0, rom_sin_reg});
        cos_v   = b_negc_reg ? -cos_mag : cos_mag;
        ysin_v  = b_negs_reg ? sin_mag : -sin_mag;      // y grows downward
        len_ext = $signed({{(PROD_W - STEP_W){1'b0}}, step_len_reg});
        prod_x  = len_ext * PROD_W'(cos_v);
        prod_y  = len_ext * PROD_W'(ysin_v);
    end

    // Stage C: round, add, saturate, settle the pose and write pushed poses to the stack.
    always_comb begin
        base_x     = c_start_reg ? start_x_reg : pos_x_reg;
        base_y     = c_start_reg ? start_y_reg : pos_y_reg;
        rnd_x      = c_prod_x_reg + ROUND_BIAS;
        rnd_y      = c_prod_y_reg + ROUND_BIAS;
        sum_x      = SUM_W'(base_x) + SUM_W'($signed(rnd_x[PROD_W-1:FRAC_W]));
        sum_y      = SUM_W'(base_y) + SUM_W'($signed(rnd_y[PROD_W-1:FRAC_W]));
        new_x      = sat_pos(sum_x);
        new_y      = sat_pos(sum_y);
        pos_x_next = base_x;
        pos_y_next = base_y;
        c_result   = '0;
        ram_we     = 1'b0;
        ram_wdata  = '{heading: c_head_reg, x: base_x, y: base_y};
        unique case (c_op_reg)
            OP_FWD: begin
                pos_x_next      = new_x;
                pos_y_next      = new_y;
                c_result.kind   = KIND_SEGMENT;
                c_result.from_x = base_x;
                c_result.from_y = base_y;
                c_result.to_x   = new_x;
                c_result.to_y   = new_y;
            end
            OP_PUSH: begin
                ram_we = c_done;
            end
            OP_POP: begin
                pos_x_next = c_pop_reg.x;
                pos_y_next = c_pop_reg.y;
            end
            OP_OVF: begin
                c_result.kind = KIND_OVERFLOW;
            end
            OP_UNF: begin
                c_result.kind = KIND_UNDERFLOW;
            end
            default: begin
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            turn_step_reg  <= TURN_STEP_RST;
            step_len_reg   <= STEP_LEN_RST;
            start_x_reg    <= START_X_RST;
            start_y_reg    <= START_Y_RST;
            start_head_reg <= START_HEAD_RST;
            heading_reg    <= START_HEAD_RST;
            count_reg      <= '0;
            pos_x_reg      <= START_X_RST;
            pos_y_reg      <= START_Y_RST;
            b_valid_reg    <= 1'b0;
            c_valid_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_TURN_STEP:     turn_step_reg  <= cfg_wdata[HEAD_W-1:0];
                    REG_STEP_LENGTH:   step_len_reg   <= cfg_wdata[STEP_W-1:0];
                    REG_START_X:       start_x_reg    <= $signed(cfg_wdata[POS_W-1:0]);
                    REG_START_Y:       start_y_reg    <= $signed(cfg_wdata[POS_W-1:0]);
                    REG_START_HEADING: start_head_reg <= cfg_wdata[HEAD_W-1:0];
                    default: begin
                    end
                endcase
            end
            heading_reg <= heading_next;
            count_reg   <= count_next;
            if (c_done) begin
                pos_x_reg <= pos_x_next;
                pos_y_reg <= pos_y_next;
            end
            if (en_ab) begin
                b_valid_reg <= accept;
            end
            if (en_bc) begin
                c_valid_reg <= b_valid_reg;
            end
            if (c_done && c_res) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            b_op_reg    <= op_a;
            b_start_reg <= s_data.start_flag;
            b_head_reg  <= head_cur;
            b_addr_reg  <= count_cur[SAW-1:0];
            b_negc_reg  <= cos_sel.neg;
            b_negs_reg  <= sin_sel.neg;
            rom_cos_reg <= QS_TABLE[cos_sel.addr];
            rom_sin_reg <= QS_TABLE[sin_sel.addr];
        end
        if (en_bc) begin
            c_op_reg     <= b_op_reg;
            c_start_reg  <= b_start_reg;
            c_head_reg   <= b_head_reg;
            c_addr_reg   <= b_addr_reg;
            c_prod_x_reg <= prod_x;
            c_prod_y_reg <= prod_y;
            c_pop_reg    <= ram_rdata;
        end
        if (c_done && c_res) begin
            m_data_reg <= c_result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Turtle path interpreter testbench
// Feeds directed and random turtle symbol streams under several register
// setups and handshake pacings. A scoreboard tracks the pose and the pose
// stack, predicts every segment and stack error item, and checks them in
// order against the result channel.
// ----------------------------------------------------------------------------

import tpi_pkg::*;

class turtle_scoreboard;
    logic [HEAD_W-1:0]       turn_step;
    logic [STEP_W-1:0]       step_len;
    logic signed [POS_W-1:0] start_x;
    logic signed [POS_W-1:0] start_y;
    logic [HEAD_W-1:0]       start_head;

    logic [HEAD_W-1:0]       heading;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    pose_t                   saved [DEF_STACK_DEPTH];
    int                      depth;

    int                      sine_q [DEF_TRIG_ENTRIES+1];
    tpi_out_t                awaited_out [$];
    int                      errors;
    int                      segments;
    int                      overflows;
    int                      underflows;

    function new();
        for (int u = 0; u <= DEF_TRIG_ENTRIES; u++) begin
            sine_q[u] = quarter_sine(u);
        end
        turn_step  = TURN_STEP_RST;
        step_len   = STEP_LEN_RST;
        start_x    = START_X_RST;
        start_y    = START_Y_RST;
        start_head = START_HEAD_RST;
        errors     = 0;
        segments   = 0;
        overflows  = 0;
        underflows = 0;
        load_start();
    endfunction

    // First-quadrant sine in Q1.14 from a truncating Q30 Taylor series.
    function int quarter_sine(int u);
        longint unsigned x;
        longint unsigned term;
        longint          sum;
        x    = (PI_Q30 * longint'(u)) / (2 * DEF_TRIG_ENTRIES);
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 10; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / ((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                sum -= longint'(term);
            end else begin
                sum += longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        return int'((sum + 32768) >>> 16);
    endfunction

    // Phase counts quarter table entries, four times the table size per turn.
    function int phase_sine(int p);
        int q;
        int r;
        q = (p / DEF_TRIG_ENTRIES) % 4;
        r = p % DEF_TRIG_ENTRIES;
        if (q == 0) begin
            return sine_q[r];
        end else if (q == 1) begin
            return sine_q[DEF_TRIG_ENTRIES - r];
        end else if (q == 2) begin
            return -sine_q[r];
        end
        return -sine_q[DEF_TRIG_ENTRIES - r];
    endfunction

    function logic signed [POS_W-1:0] clamp(longint v);
        if (v > longint'(POS_MAX)) begin
            return POS_MAX;
        end else if (v < longint'(POS_MIN)) begin
            return POS_MIN;
        end
        return v[POS_W-1:0];
    endfunction

    function void load_start();
        heading = start_head;
        pos_x   = start_x;
        pos_y   = start_y;
        depth   = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_TURN_STEP:     turn_step  = data[HEAD_W-1:0];
            REG_STEP_LENGTH:   step_len   = data[STEP_W-1:0];
            REG_START_X:       start_x    = data[POS_W-1:0];
            REG_START_Y:       start_y    = data[POS_W-1:0];
            REG_START_HEADING: start_head = data[HEAD_W-1:0];
            default: ;
        endcase
    endfunction

    function void apply_symbol(tpi_in_t it);
        tpi_out_t res;
        int       idx;
        int       p;
        int       pc;
        longint   len;
        longint   dx;
        longint   dy;
        if (it.start_flag) begin
            load_start();
        end
        res = '0;
        case (it.symbol)
            SYM_FORWARD: begin
                idx = (int'(heading) * DEF_TRIG_ENTRIES) >> 16;
                p   = 4 * idx;
                pc  = (p + DEF_TRIG_ENTRIES) % (4 * DEF_TRIG_ENTRIES);
                len = longint'(step_len);
                dx  = (len * phase_sine(pc) + 8192) >>> 14;
                // Screen y grows downward, so a positive sine moves up.
                dy  = (-(len * phase_sine(p)) + 8192) >>> 14;
                res.kind   = KIND_SEGMENT;
                res.from_x = pos_x;
                res.from_y = pos_y;
                res.to_x   = clamp(longint'(pos_x) + dx);
                res.to_y   = clamp(longint'(pos_y) + dy);
                pos_x      = res.to_x;
                pos_y      = res.to_y;
                awaited_out.insert(awaited_out.size(), res);
                segments++;
            end
            SYM_LEFT: begin
                heading = heading + turn_step;
            end
            SYM_RIGHT: begin
                heading = heading - turn_step;
            end
            SYM_PUSH: begin
                if (depth >= DEF_STACK_DEPTH) begin
                    res.kind = KIND_OVERFLOW;
                    awaited_out.insert(awaited_out.size(), res);
                    overflows++;
                end else begin
                    saved[depth].heading = heading;
                    saved[depth].x       = pos_x;
                    saved[depth].y       = pos_y;
                    depth++;
                end
            end
            SYM_POP: begin
                if (depth == 0) begin
                    res.kind = KIND_UNDERFLOW;
                    awaited_out.insert(awaited_out.size(), res);
                    underflows++;
                end else begin
                    depth--;
                    heading = saved[depth].heading;
                    pos_x   = saved[depth].x;
                    pos_y   = saved[depth].y;
                end
            end
            default: ;
        endcase
    endfunction

    function void check_out(tpi_out_t got);
        tpi_out_t want;
        if (awaited_out.size() == 0) begin
            errors++;
            if (errors <= 10) begin
                $display("Unexpected item: kind %0d (%0d, %0d) -> (%0d, %0d)",
                         got.kind, got.from_x, got.from_y, got.to_x, got.to_y);
            end
            return;
        end
        want = awaited_out.pop_front();
        if (got.kind !== want.kind || got.from_x !== want.from_x ||
            got.from_y !== want.from_y || got.to_x !== want.to_x ||
            got.to_y !== want.to_y) begin
            errors++;
            if (errors <= 10) begin
                $display("Mismatch: expected kind %0d (%0d, %0d) -> (%0d, %0d)",
                         want.kind, want.from_x, want.from_y, want.to_x, want.to_y);
                $display("          actual   kind %0d (%0d, %0d) -> (%0d, %0d)",
                         got.kind, got.from_x, got.from_y, got.to_x, got.to_y);
            end
        end
    endfunction

    function void close_out();
        if (awaited_out.size() != 0) begin
            $display("%0d predicted items never arrived", awaited_out.size());
            errors += awaited_out.size();
        end
    endfunction
endclass

module testbench;
    localparam int LIMIT_CYCLES    = 400000;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 250;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd7;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_valid;
    logic                   s_ready;
    tpi_in_t                s_data;
    logic                   m_valid;
    logic                   m_ready;
    tpi_out_t               m_data;

    int src_idle   = 0;
    int sink_stall = 0;
    int cycles     = 0;
    int sent       = 0;
    int counted    = 0;

    turtle_scoreboard sb;

    turtle_path_interpreter u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    // Result side: check what is accepted at this edge, then pick the next ready.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                sb.check_out(m_data);
            end
            m_ready <= ($urandom_range(99) >= sink_stall);
        end
    end

    // Called right after a rising edge; returns at the edge that accepts the item.
    task automatic send_item(input logic [7:0] sym, input logic flag);
        tpi_in_t it;
        it.symbol     = sym;
        it.start_flag = flag;
        if (src_idle != 0 && $urandom_range(99) < src_idle) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        sb.apply_symbol(it);
        sent++;
        if (sym inside {SYM_FORWARD, SYM_LEFT, SYM_RIGHT, SYM_PUSH, SYM_POP}) begin
            counted++;
        end
    endtask

    // Turns and successful stack moves leave no result, so allow for them in flight.
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.awaited_out.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        sb.write_reg(idx, data);
    endtask

    task automatic set_config(input int phase);
        case (phase)
            1: begin
                // Bits above the turn step, step length and start heading widths are set and must be dropped.
                write_reg(REG_TURN_STEP, 20'hF8000);
                write_reg(REG_STEP_LENGTH, 20'hFFFFF);
                write_reg(REG_START_X, POS_MAX);
                write_reg(REG_START_Y, POS_MIN);
                write_reg(REG_START_HEADING, 20'hFFFFF);
            end
            2: begin
                write_reg(REG_TURN_STEP, 20'd0);
                write_reg(REG_STEP_LENGTH, 20'd0);
                write_reg(REG_START_X, POS_MIN);
                write_reg(REG_START_Y, POS_MAX);
                write_reg(REG_START_HEADING, 20'd0);
            end
            3: begin
                write_reg(REG_TURN_STEP, 20'd16384);
                write_reg(REG_STEP_LENGTH, 20'd262144);
                write_reg(REG_START_X, 20'd0);
                write_reg(REG_START_Y, 20'd0);
                write_reg(REG_START_HEADING, 20'd32768);
                write_reg(REG_SPARE, 20'h5A5A5);
            end
            default: begin
                write_reg(REG_TURN_STEP, 20'($urandom_range(0, 32768)));
                if ($urandom_range(3) == 0) begin
                    write_reg(REG_STEP_LENGTH, 20'($urandom_range(0, 524287)));
                end else begin
                    write_reg(REG_STEP_LENGTH, 20'($urandom_range(0, 4095)));
                end
                write_reg(REG_START_X, 20'($urandom));
                write_reg(REG_START_Y, 20'($urandom));
                write_reg(REG_START_HEADING, 20'($urandom_range(0, 65535)));
            end
        endcase
        cfg_wr_en <= 1'b0;
    endtask

    // A bracketed turtle string with random content; open branches are closed.
    task automatic run_sentence();
        int         n;
        int         open;
        int         r;
        logic [7:0] sym;
        n    = $urandom_range(4, 40);
        open = 0;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 35) begin
                sym = SYM_FORWARD;
            end else if (r < 50) begin
                sym = SYM_LEFT;
            end else if (r < 65) begin
                sym = SYM_RIGHT;
            end else if (r < 78 && open < 24) begin
                sym = SYM_PUSH;
                open++;
            end else if (r < 92 && open > 0) begin
                sym = SYM_POP;
                open--;
            end else begin
                sym = 8'($urandom_range(0, 255));
            end
            send_item(sym, i == 0 && $urandom_range(2) == 0);
        end
        while (open > 0) begin
            send_item(SYM_POP, 1'b0);
            open--;
        end
    endtask

    // Pushes near or past the stack depth, then pops two more than it pushed.
    task automatic run_deep();
        int n;
        n = $urandom_range(DEF_STACK_DEPTH - 4, DEF_STACK_DEPTH + 4);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(3) == 0) begin
                send_item(($urandom_range(1) == 0) ? SYM_FORWARD : SYM_LEFT, 1'b0);
            end
            send_item(SYM_PUSH, i == 0 && $urandom_range(1) == 0);
        end
        for (int i = 0; i < n + 2; i++) begin
            send_item(SYM_POP, 1'b0);
            if ($urandom_range(4) == 0) begin
                send_item(SYM_FORWARD, 1'b0);
            end
        end
    endtask

    task automatic run_noise();
        int n;
        int r;
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(3);
            send_item((r == 0) ? 8'($urandom_range(0, 255)) :
                      (r == 1) ? SYM_PUSH : (r == 2) ? SYM_POP : SYM_FORWARD,
                      $urandom_range(7) == 0);
        end
    endtask

    initial begin
        int base;
        int r;
        bit paused;
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_data    = '0;
        sb        = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed walk with the reset pose: moves, turns, stack underflows,
        // a pop right behind its push, ignored bytes and start reloads.
        send_item(SYM_FORWARD, 1'b0);
        send_item(SYM_POP, 1'b0);
        send_item(SYM_PUSH, 1'b0);
        send_item(SYM_LEFT, 1'b0);
        send_item(SYM_FORWARD, 1'b0);
        send_item(SYM_RIGHT, 1'b0);
        send_item(SYM_RIGHT, 1'b0);
        send_item(SYM_FORWARD, 1'b0);
        send_item(SYM_POP, 1'b0);
        send_item(SYM_FORWARD, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h66, 1'b0);
        send_item(SYM_PUSH, 1'b0);
        send_item(SYM_POP, 1'b0);
        send_item(SYM_PUSH, 1'b0);
        send_item(SYM_PUSH, 1'b0);
        send_item(SYM_POP, 1'b1);
        send_item(SYM_FORWARD, 1'b1);
        send_item(8'hFF, 1'b1);
        send_item(SYM_LEFT, 1'b1);
        send_item(SYM_FORWARD, 1'b0);
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph != 0) begin
                set_config(ph);
            end
            case (ph % 4)
                0: begin src_idle = 0;  sink_stall = 0;  end
                1: begin src_idle = 85; sink_stall = 0;  end
                2: begin src_idle = 0;  sink_stall = 85; end
                default: begin src_idle = 23; sink_stall = 23; end
            endcase
            base   = sent;
            paused = 1'b0;
            send_item(SYM_FORWARD, 1'b1);
            while (sent - base < ITEMS_PER_PHASE) begin
                r = $urandom_range(99);
                if (r < 4) begin
                    run_deep();
                end else if (r < 84) begin
                    run_sentence();
                end else begin
                    run_noise();
                end
                if (!paused && sent - base >= ITEMS_PER_PHASE / 2) begin
                    drain();
                    paused = 1'b1;
                end
            end
            drain();
        end

        sb.close_out();
        $display("Sent %0d symbols (%0d turtle commands) over %0d register setups.",
                 sent, counted, PHASES);
        $display("Checked %0d segments, %0d stack overflows and %0d stack underflows.",
                 sb.segments, sb.overflows, sb.underflows);
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d failures", sb.errors);
            $display("Verification failed");
        end
        $finish;
    end
endmodule
